@@ sv/pls_pkg.sv @@
// shared types and constants for the priority load shedder
package pls_pkg;

    localparam int TAG_W  = 16;
    localparam int PWR_W  = 16;
    localparam int PRIO_W = 8;
    localparam int CAP_W  = 24;
    localparam int USED_W = 21;

    // register index of the supply capacity
    localparam logic CAP_INDEX = 1'b0;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PWR_W-1:0]  power;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic [TAG_W-1:0]  load_tag;
        logic [PWR_W-1:0]  load_power;
        logic [PRIO_W-1:0] load_priority;
        logic              final_load;
    } load_req_t;

    typedef struct packed {
        logic [TAG_W-1:0]  result_tag;
        logic              is_served;
        logic [USED_W-1:0] used_total;
        logic              last_result;
        logic              set_overflow;
    } result_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctl_t;

    typedef enum logic {
        ST_LOAD,
        ST_EVAL
    } state_t;

endpackage

@@ sv/priority_load_shedder_core.sv @@
// top level of the priority load shedder: cell chain, control and register port
//
//   channel   direction  handshake                    payload
//   load      in         load_valid / load_stall      load_req_t
//   result    out        result_valid / result_stall  result_t
//   apb       in/out     psel penable pwrite pready   paddr pwdata prdata
//
// a load is sorted into the cell chain as it arrives (dropped, with overflow
// set, if the chain is full); after the final load, evaluation walks the chain,
// shifting its head into the single capacity adder; load_stall is high meanwhile
// result_stall freezes the result register and the walk, no result is lost
// reset empties the set at once, with no clearing pass; capacity resets to zero
module priority_load_shedder_core #(
    parameter int MAX_LOADS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load_valid,
    output logic               load_stall,
    input  pls_pkg::load_req_t load,
    output logic               result_valid,
    input  logic               result_stall,
    output pls_pkg::result_t   result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CNT_W = $clog2(MAX_LOADS + 1);

    pls_pkg::state_t            state_reg;
    pls_pkg::state_t            state_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       overflow_reg;
    logic                       overflow_next;
    logic [pls_pkg::CAP_W-1:0]  cap_reg;
    logic [pls_pkg::CAP_W-1:0]  cap_next;

    logic                       accept;
    logic                       full;
    logic                       step;
    logic                       last;
    pls_pkg::cell_ctl_t         ctl;
    pls_pkg::entry_t            new_entry;
    pls_pkg::entry_t            cells   [MAX_LOADS];
    logic                       conds   [MAX_LOADS];
    logic                       cfg_wr;

    assign accept = load_valid && !load_stall;
    assign full   = count_reg == CNT_W'(MAX_LOADS);
    assign last   = count_reg == CNT_W'(1);

    assign new_entry.tag   = load.load_tag;
    assign new_entry.power = load.load_power;
    assign new_entry.prio  = load.load_priority;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pls_pkg::ST_LOAD:
            begin
                if (accept && load.final_load)
                begin
                    state_next = pls_pkg::ST_EVAL;
                end
            end
            pls_pkg::ST_EVAL:
            begin
                if (step && last)
                begin
                    state_next = pls_pkg::ST_LOAD;
                end
            end
            default: state_next = pls_pkg::ST_LOAD;
        endcase
    end

    // outputs of the control
    always_comb
    begin
        load_stall = 1'b0;
        step       = 1'b0;
        ctl.insert = 1'b0;
        ctl.shift  = 1'b0;
        unique case (state_reg)
            pls_pkg::ST_LOAD:
            begin
                // loads are never stalled while collecting
                ctl.insert = load_valid && !full;
            end
            pls_pkg::ST_EVAL:
            begin
                load_stall = 1'b1;
                step       = !result_valid || !result_stall;
                ctl.shift  = step;
            end
            default: load_stall = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (ctl.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (accept && full)
        begin
            overflow_next = 1'b1;
        end
        if (step)
        begin
            count_next = count_reg - CNT_W'(1);
            if (last)
            begin
                overflow_next = 1'b0;
            end
        end
    end

    // register port
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == pls_pkg::CAP_INDEX);
    assign cap_next = cfg_wr ? pwdata[pls_pkg::CAP_W-1:0] : cap_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == pls_pkg::CAP_INDEX) ?
                      {{(32 - pls_pkg::CAP_W){1'b0}}, cap_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pls_pkg::ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            cap_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            cap_reg      <= cap_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < MAX_LOADS; i++)
        begin : g_cell
            pls_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (count_reg > CNT_W'(i)),
                .new_entry   (new_entry),
                .lower_entry ((i == 0) ? new_entry : cells[(i == 0) ? 0 : i - 1]),
                .lower_cond  ((i == 0) ? 1'b0 : conds[(i == 0) ? 0 : i - 1]),
                .upper_entry (cells[(i == MAX_LOADS - 1) ? i : i + 1]),
                .entry       (cells[i]),
                .cond        (conds[i])
            );
        end
    endgenerate

    pls_eval u_eval (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .head         (cells[0]),
        .last         (last),
        .overflow     (overflow_reg),
        .cap          (cap_reg),
        .result_stall (result_stall),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

@@ sv/pls_cell.sv @@
// one sorting cell: holds one load, takes a new one or its lower neighbor's on insert, its upper neighbor's on shift
module pls_cell (
    input  logic               clk,
    input  pls_pkg::cell_ctl_t ctl,
    input  logic               occupied,
    input  pls_pkg::entry_t    new_entry,
    input  pls_pkg::entry_t    lower_entry,
    input  logic               lower_cond,
    input  pls_pkg::entry_t    upper_entry,
    output pls_pkg::entry_t    entry,
    output logic               cond
);

    pls_pkg::entry_t entry_reg;
    pls_pkg::entry_t entry_next;

    // strictly larger priority moves up, equal stays ahead
    assign cond  = !occupied || (entry_reg.prio > new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.insert && cond)
        begin
            entry_next = lower_cond ? lower_entry : new_entry;
        end
        else if (ctl.shift)
        begin
            entry_next = upper_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ sv/pls_eval.sv @@
// evaluation stage: capacity check, running total and result register
module pls_eval (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  pls_pkg::entry_t               head,
    input  logic                          last,
    input  logic                          overflow,
    input  logic [pls_pkg::CAP_W-1:0]     cap,
    input  logic                          result_stall,
    output pls_pkg::result_t              result,
    output logic                          result_valid
);

    logic [pls_pkg::USED_W-1:0] used_reg;
    logic [pls_pkg::USED_W-1:0] used_next;
    logic                       valid_reg;
    logic                       valid_next;
    pls_pkg::result_t           result_reg;
    pls_pkg::result_t           result_next;
    logic [pls_pkg::USED_W:0]   sum;
    logic                       fits;

    assign sum  = {1'b0, used_reg} + {{(pls_pkg::USED_W + 1 - pls_pkg::PWR_W){1'b0}}, head.power};
    assign fits = {{(pls_pkg::CAP_W - pls_pkg::USED_W - 1){1'b0}}, sum} <= cap;

    always_comb
    begin
        used_next   = used_reg;
        valid_next  = valid_reg && result_stall;
        result_next = result_reg;
        if (step)
        begin
            valid_next = 1'b1;
            result_next.result_tag   = head.tag;
            result_next.is_served    = fits;
            result_next.used_total   = fits ? sum[pls_pkg::USED_W-1:0] : used_reg;
            result_next.last_result  = last;
            result_next.set_overflow = overflow;
            if (last)
            begin
                used_next = '0;
            end
            else if (fits)
            begin
                used_next = sum[pls_pkg::USED_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            used_reg  <= used_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule

@@ sv/pls_checker.sv @@
// port-level checks for the priority load shedder, bound to the top level
module pls_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               load_valid,
    input logic               load_stall,
    input pls_pkg::load_req_t load,
    input logic               result_valid,
    input logic               result_stall,
    input pls_pkg::result_t   result,
    input logic               pready
);

    // a waiting result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // loads are blocked only after a final load request
    a_stall_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(load_stall) |-> $past(load_valid && load.final_load))
        else $error("load stall without final load");

    // a result other than the last one means evaluation is still running
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_result |-> load_stall)
        else $error("loads accepted during evaluation");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind priority_load_shedder_core pls_checker u_pls_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_valid   (load_valid),
    .load_stall   (load_stall),
    .load         (load),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .pready       (pready)
);

@@ dv/priority_load_shedder_core_tb.sv @@
// testbench for the priority load shedder core: random load sets, capacity changes, scoreboard
module priority_load_shedder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_DEPTH    = 32;
    localparam int RANDOM_LOADS = 430;
    localparam int SETTLE_CYCLES = 4;

    // shadow of the block: stable priority-ordered store and served-power walk
    class load_scoreboard;
        pls_pkg::entry_t            ordered_loads[SET_DEPTH];
        int                         stored_loads;
        bit                         dropped_load;
        logic [pls_pkg::CAP_W-1:0]  capacity;
        pls_pkg::result_t           expected_results[$];
        int                         errors;

        function void note_load(pls_pkg::load_req_t req);
            int                           pos;
            logic [pls_pkg::USED_W+3:0]   used;
            pls_pkg::result_t             res;
            if (stored_loads >= SET_DEPTH)
            begin
                dropped_load = 1'b1;
            end
            else
            begin
                pos = stored_loads;
                // strictly larger priorities move up, equal ones keep arrival order
                while (pos > 0 && ordered_loads[pos-1].prio > req.load_priority)
                begin
                    ordered_loads[pos] = ordered_loads[pos-1];
                    pos--;
                end
                ordered_loads[pos].tag   = req.load_tag;
                ordered_loads[pos].power = req.load_power;
                ordered_loads[pos].prio  = req.load_priority;
                stored_loads++;
            end
            if (req.final_load)
            begin
                used = '0;
                for (int k = 0; k < stored_loads; k++)
                begin
                    res.is_served = 1'b0;
                    if (used + ordered_loads[k].power <= capacity)
                    begin
                        used = used + ordered_loads[k].power;
                        res.is_served = 1'b1;
                    end
                    res.result_tag   = ordered_loads[k].tag;
                    res.used_total   = used[pls_pkg::USED_W-1:0];
                    res.last_result  = (k == stored_loads - 1);
                    res.set_overflow = dropped_load;
                    expected_results = {expected_results, res};
                end
                stored_loads = 0;
                dropped_load = 1'b0;
            end
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(pls_pkg::result_t got);
            pls_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("unexpected result tag %h", got.result_tag));
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.result_tag !== want.result_tag)
                    report($sformatf("result_tag got %h want %h",
                                     got.result_tag, want.result_tag));
                if (got.is_served !== want.is_served)
                    report($sformatf("is_served tag %h got %b want %b",
                                     want.result_tag, got.is_served, want.is_served));
                if (got.used_total !== want.used_total)
                    report($sformatf("used_total tag %h got %h want %h",
                                     want.result_tag, got.used_total, want.used_total));
                if (got.last_result !== want.last_result)
                    report($sformatf("last_result tag %h got %b want %b",
                                     want.result_tag, got.last_result, want.last_result));
                if (got.set_overflow !== want.set_overflow)
                    report($sformatf("set_overflow tag %h got %b want %b",
                                     want.result_tag, got.set_overflow, want.set_overflow));
            end
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               load_valid;
    logic               load_stall;
    pls_pkg::load_req_t load;
    logic               result_valid;
    logic               result_stall;
    pls_pkg::result_t   result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    load_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int loads_sent;
    int sets_done;

    priority_load_shedder_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (load_valid),
        .load_stall   (load_stall),
        .load         (load),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    function automatic pls_pkg::load_req_t make_load(logic [pls_pkg::TAG_W-1:0] tag,
                                                     logic [pls_pkg::PWR_W-1:0] power,
                                                     logic [pls_pkg::PRIO_W-1:0] prio,
                                                     logic fin);
        pls_pkg::load_req_t req;
        req.load_tag      = tag;
        req.load_power    = power;
        req.load_priority = prio;
        req.final_load    = fin;
        return req;
    endfunction

    task automatic send_load(pls_pkg::load_req_t req);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            load_valid <= 1'b0;
            load       <= pls_pkg::load_req_t'($urandom);
            @(negedge clk);
        end
        load_valid <= 1'b1;
        load       <= req;
        do
            @(posedge clk);
        while (load_stall);
        sb.note_load(req);
    endtask

    // let the block finish the set before touching the register
    task automatic drain_set();
        @(negedge clk);
        load_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [pls_pkg::CAP_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {pls_pkg::CAP_INDEX, 2'b00};
        pwdata  <= {{(32-pls_pkg::CAP_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.capacity = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random_set();
        int                 n;
        int                 pick;
        bit                 narrow_prio;
        pls_pkg::load_req_t req;
        pick = $urandom_range(99);
        if (sets_done == 0)
            n = SET_DEPTH + 2;
        else if (pick < 70)
            n = $urandom_range(10, 1);
        else if (pick < 85)
            n = $urandom_range(SET_DEPTH - 1, 11);
        else if (pick < 93)
            n = SET_DEPTH;
        else
            n = $urandom_range(SET_DEPTH + 8, SET_DEPTH + 1);
        // narrow priorities give many ties
        narrow_prio = ($urandom_range(1) != 0);
        for (int i = 0; i < n; i++)
        begin
            req.load_tag      = pls_pkg::TAG_W'($urandom);
            req.load_power    = ($urandom_range(3) == 0) ?
                                pls_pkg::PWR_W'($urandom_range(255)) :
                                pls_pkg::PWR_W'($urandom);
            req.load_priority = narrow_prio ? pls_pkg::PRIO_W'($urandom_range(3)) :
                                              pls_pkg::PRIO_W'($urandom);
            req.final_load    = (i == n - 1);
            send_load(req);
            loads_sent++;
        end
        sets_done++;
    endtask

    initial
    begin
        #5_000_000;
        $display("FAIL priority_load_shedder_core");
        $finish;
    end

    initial
    begin
        sb = new();
        sb.capacity   = '0;
        clk           = 1'b0;
        rst_n         = 1'b0;
        load_valid    = 1'b0;
        load          = '0;
        result_stall  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        loads_sent    = 0;
        sets_done     = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero capacity after reset: only a zero-power load fits
        send_load(make_load(16'hFFFF, 16'h0001, 8'hFF, 1'b0));
        send_load(make_load(16'h0000, 16'h0000, 8'h00, 1'b1));

        drain_set();
        write_capacity(24'hFFFFFF);
        send_load(make_load(16'h0101, 16'hFFFF, 8'hFF, 1'b0));
        send_load(make_load(16'h0202, 16'hFFFF, 8'h00, 1'b0));
        send_load(make_load(16'h0303, 16'hFFFF, 8'hFF, 1'b0));
        send_load(make_load(16'h0404, 16'h0000, 8'h80, 1'b0));
        send_load(make_load(16'h0505, 16'hFFFF, 8'h00, 1'b0));
        send_load(make_load(16'hAAAA, 16'h5555, 8'h7F, 1'b1));

        // ties keep arrival order, a shed load lets a smaller later one fit
        drain_set();
        write_capacity(24'd100);
        send_load(make_load(16'h1001, 16'd40, 8'd5, 1'b0));
        send_load(make_load(16'h1002, 16'd60, 8'd3, 1'b0));
        send_load(make_load(16'h1003, 16'd30, 8'd5, 1'b0));
        send_load(make_load(16'h1004, 16'd50, 8'd3, 1'b0));
        send_load(make_load(16'h1005, 16'd10, 8'd0, 1'b0));
        send_load(make_load(16'h1006, 16'd1, 8'd255, 1'b1));

        // single load exactly at capacity
        send_load(make_load(16'h1234, 16'd100, 8'd7, 1'b1));

        loads_sent = 0;
        while (loads_sent < RANDOM_LOADS)
        begin
            case (loads_sent * 4 / RANDOM_LOADS)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 52;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 52;
                end
                default:
                begin
                    send_idle_pct = 21;
                    stall_pct     = 21;
                end
            endcase
            if ($urandom_range(2) == 0)
            begin
                drain_set();
                case ($urandom_range(3))
                    0: write_capacity('0);
                    1: write_capacity(24'hFFFFFF);
                    2: write_capacity(pls_pkg::CAP_W'($urandom));
                    default: write_capacity(pls_pkg::CAP_W'($urandom_range(200000)));
                endcase
            end
            run_random_set();
        end

        drain_set();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS priority_load_shedder_core");
        else
            $display("FAIL priority_load_shedder_core");
        $finish;
    end

endmodule

@@ files.f @@
sv/pls_pkg.sv
sv/pls_cell.sv
sv/pls_eval.sv
sv/priority_load_shedder_core.sv
sv/pls_checker.sv
dv/priority_load_shedder_core_tb.sv
